>>> sv/kir_pkg.sv
// kir_pkg: shared types, request codes and translation tables for the keyboard block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kir_pkg;

  localparam int unsigned CodeW  = 10;
  localparam int unsigned KeyW   = 6;
  localparam int unsigned LevelW = 3;
  localparam int unsigned ModW   = 4;

  // modifier bits as they sit in a latched code
  localparam logic [CodeW-1:0] BitShift = 10'o0100;
  localparam logic [CodeW-1:0] BitCtrl  = 10'o0200;
  localparam logic [CodeW-1:0] BitTop   = 10'o0400;
  localparam logic [CodeW-1:0] BitMeta  = 10'o1000;

  typedef enum logic [2:0] {
    REQ_KEY       = 3'd0,
    REQ_ASCII     = 3'd1,
    REQ_WR_LEVEL  = 3'd2,
    REQ_RD_STATUS = 3'd3,
    REQ_RD_CODE   = 3'd4,
    REQ_WR_DATA   = 3'd5
  } req_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [6:0]        key_id;
    logic              key_down;
    logic [6:0]        ascii_char;
    logic [LevelW-1:0] level_value;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0]  read_data;
    logic              event_unused;
    logic              irq_active;
    logic [LevelW-1:0] irq_level;
  } result_t;

  // decoded key / character lookups handed from translation to execution
  typedef struct packed {
    logic             mod_hit;
    logic [1:0]       mod_idx;
    logic             key_hit;
    logic [KeyW-1:0]  key_sym;
    logic [CodeW-1:0] ascii_code;
  } xlate_t;

  // key code for dense key numbers 10..63, zero elsewhere
  function automatic logic [KeyW-1:0] key_sym_of(logic [6:0] id);
    logic [KeyW-1:0] code;
    code = '0;
    if (id == 7'd10) begin
      code = 6'o53;
    end else if (id >= 7'd11 && id <= 7'd19) begin
      code = 6'(id + 7'd38);
    end else if (id >= 7'd20 && id <= 7'd45) begin
      code = 6'(id - 7'd19);
    end else begin
      case (id)
        7'd46:   code = 6'o60;
        7'd47:   code = 6'o55;
        7'd48:   code = 6'o52;
        7'd49:   code = 6'o50;
        7'd50:   code = 6'o51;
        7'd51:   code = 6'o73;
        7'd52:   code = 6'o72;
        7'd53:   code = 6'o34;
        7'd54:   code = 6'o34;
        7'd55:   code = 6'o54;
        7'd56:   code = 6'o56;
        7'd57:   code = 6'o57;
        7'd58:   code = 6'o77;
        7'd59:   code = 6'o74;
        7'd60:   code = 6'o74;
        7'd61:   code = 6'o45;
        7'd62:   code = 6'o33;
        7'd63:   code = 6'o40;
        default: code = '0;
      endcase
    end
    return code;
  endfunction

  // console character to full code, modifiers included
  function automatic logic [CodeW-1:0] ascii_code_of(logic [6:0] ch);
    logic [CodeW-1:0] code;
    code = '0;
    if ((ch >= 7'd1 && ch <= 7'd8) || (ch >= 7'd14 && ch <= 7'd26) ||
        ch == 7'd28 || ch == 7'd29 || ch == 7'd31) begin
      code = BitCtrl | {4'b0, ch[5:0]};
    end else if (ch >= 7'd40 && ch <= 7'd59) begin
      code = {3'b0, ch};
    end else if (ch >= 7'd65 && ch <= 7'd90) begin
      code = BitShift | {5'b0, ch[4:0]};
    end else if (ch >= 7'd97 && ch <= 7'd122) begin
      code = {5'b0, ch[4:0]};
    end else begin
      case (ch)
        7'd9:    code = 10'o045;
        7'd10:   code = 10'o035;
        7'd11:   code = 10'o047;
        7'd12:   code = 10'o046;
        7'd13:   code = 10'o033;
        7'd27:   code = 10'o077;
        7'd32:   code = 10'o040;
        7'd33:   code = BitShift | 10'o054;
        7'd34:   code = BitTop   | 10'o031;
        7'd35:   code = BitTop   | 10'o022;
        7'd36:   code = BitShift | 10'o066;
        7'd37:   code = BitShift | 10'o067;
        7'd38:   code = BitTop   | 10'o024;
        7'd39:   code = BitTop   | 10'o011;
        7'd60:   code = BitTop   | 10'o004;
        7'd61:   code = BitTop   | 10'o010;
        7'd62:   code = BitTop   | 10'o006;
        7'd63:   code = BitTop   | 10'o056;
        7'd64:   code = BitTop   | 10'o005;
        7'd91:   code = BitTop   | 10'o050;
        7'd92:   code = 10'o034;
        7'd93:   code = BitTop   | 10'o051;
        7'd95:   code = BitTop   | 10'o071;
        7'd96:   code = BitTop   | 10'o025;
        7'd123:  code = BitTop   | 10'o017;
        7'd124:  code = BitShift | 10'o053;
        7'd125:  code = BitTop   | 10'o020;
        7'd126:  code = BitShift | 10'o070;
        7'd127:  code = 10'o074;
        default: code = '0;
      endcase
    end
    return code;
  endfunction

endpackage

>>> sv/kir_if.sv
// kir_in_if / kir_out_if: valid-ready channels for request and result beats
// depends on kir_pkg for widths
`timescale 1ns / 1ps

interface kir_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                req_type;
  logic [6:0]                key_id;
  logic                      key_down;
  logic [6:0]                ascii_char;
  logic [kir_pkg::LevelW-1:0] level_value;

  modport source (output valid, req_type, key_id, key_down, ascii_char, level_value,
                  input ready);
  modport sink   (input valid, req_type, key_id, key_down, ascii_char, level_value,
                  output ready);
endinterface

interface kir_out_if;
  logic                      valid;
  logic                      ready;
  logic [kir_pkg::CodeW-1:0]  read_data;
  logic                      event_unused;
  logic                      irq_active;
  logic [kir_pkg::LevelW-1:0] irq_level;

  modport source (output valid, read_data, event_unused, irq_active, irq_level,
                  input ready);
  modport sink   (input valid, read_data, event_unused, irq_active, irq_level,
                  output ready);
endinterface

>>> sv/kir_in_reg.sv
// kir_in_reg: input register stage holding one request beat
// depends on kir_pkg
`timescale 1ns / 1ps

module kir_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kir_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output kir_pkg::item_t item_o
);
  import kir_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // free slot, or the held beat leaves this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/kir_xlate.sv
// kir_xlate: decodes key numbers and console characters into codes
// depends on kir_pkg (key and character tables)
`timescale 1ns / 1ps

module kir_xlate (
  input  kir_pkg::item_t  item_i,
  output kir_pkg::xlate_t xlate_o
);
  import kir_pkg::*;

  always_comb begin
    xlate_o.mod_hit = 1'b1;
    xlate_o.mod_idx = 2'd0;
    case (item_i.key_id)
      7'd1, 7'd2:        xlate_o.mod_idx = 2'd0;
      7'd3, 7'd4, 7'd5:  xlate_o.mod_idx = 2'd1; // caps lock counts as control
      7'd6, 7'd7:        xlate_o.mod_idx = 2'd2;
      7'd8, 7'd9:        xlate_o.mod_idx = 2'd3;
      default:           xlate_o.mod_hit = 1'b0;
    endcase
    xlate_o.key_hit    = (item_i.key_id >= 7'd10) && (item_i.key_id <= 7'd63);
    xlate_o.key_sym    = key_sym_of(item_i.key_id);
    xlate_o.ascii_code = ascii_code_of(item_i.ascii_char);
  end

endmodule

>>> sv/kir_exec.sv
// kir_exec: interface state registers, request execution and result register
// depends on kir_pkg; fed by kir_in_reg and kir_xlate
`timescale 1ns / 1ps

module kir_exec (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  kir_pkg::item_t   item_i,
  input  kir_pkg::xlate_t  xlate_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output kir_pkg::result_t result_o
);
  import kir_pkg::*;

  logic [LevelW-1:0] level_q, level_d;
  logic              done_q, done_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [ModW-1:0]   mod_q, mod_d;
  logic              irq_q, irq_d;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;
  logic              do_latch;
  logic [CodeW-1:0]  latch_code;

  always_comb begin
    level_d    = level_q;
    done_d     = done_q;
    code_d     = code_q;
    mod_d      = mod_q;
    irq_d      = irq_q;
    do_latch   = 1'b0;
    latch_code = xlate_i.ascii_code;
    result_d   = '0;

    case (req_e'(item_i.req_type))
      REQ_KEY: begin
        if (xlate_i.mod_hit) begin
          mod_d[xlate_i.mod_idx] = item_i.key_down;
        end else if (item_i.key_down && xlate_i.key_hit) begin
          do_latch   = 1'b1;
          latch_code = {mod_q, xlate_i.key_sym};
        end else begin
          result_d.event_unused = 1'b1;
        end
      end
      REQ_ASCII: begin
        do_latch = (item_i.ascii_char != 7'd0);
      end
      REQ_WR_LEVEL: begin
        level_d = item_i.level_value;
      end
      REQ_RD_STATUS: begin
        result_d.read_data = {{(CodeW-LevelW-1){1'b0}}, done_q, level_q};
      end
      REQ_RD_CODE: begin
        done_d             = 1'b0;
        irq_d              = 1'b0;
        result_d.read_data = code_q;
      end
      default: ;
    endcase

    // a latch at level zero sets done but does not raise the interrupt
    if (do_latch) begin
      code_d = latch_code;
      done_d = 1'b1;
      if (level_q != '0) begin
        irq_d = 1'b1;
      end
    end

    result_d.irq_active = irq_d;
    result_d.irq_level  = level_d;

    out_valid_d = out_valid_q;
    if (fire_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      done_q      <= 1'b0;
      code_q      <= '0;
      mod_q       <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire_i) begin
        level_q <= level_d;
        done_q  <= done_d;
        code_q  <= code_d;
        mod_q   <= mod_d;
        irq_q   <= irq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

>>> sv/keyboard_interface_registers.sv
// keyboard_interface_registers: top level of the keyboard interface block
// depends on kir_pkg, kir_if, kir_in_reg, kir_xlate, kir_exec
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    req_type, key_id, key_down, ascii_char, level_value
//   out_o    out  valid/ready    read_data, event_unused, irq_active, irq_level
//
// one result beat per request beat; a request passes the input register, then table lookup
// and state update into the result register
// sustained rate is one beat per cycle while out_o keeps taking results
// a stalled output holds its beat; one more request waits in the input register
// reset clears all interface state (level, done, code, modifiers, interrupt)
`timescale 1ns / 1ps

module keyboard_interface_registers (
  input logic      clk_i,
  input logic      rst_ni,
  kir_in_if.sink   in_i,
  kir_out_if.source out_o
);
  import kir_pkg::*;

  item_t   in_item;
  item_t   s0_item;
  logic    s0_valid;
  logic    advance;
  logic    out_valid;
  xlate_t  xlate;
  result_t result;

  assign in_item.req_type    = in_i.req_type;
  assign in_item.key_id      = in_i.key_id;
  assign in_item.key_down    = in_i.key_down;
  assign in_item.ascii_char  = in_i.ascii_char;
  assign in_item.level_value = in_i.level_value;

  // held request moves on when the result register is free or being emptied
  assign advance = s0_valid && (!out_valid || out_o.ready);

  kir_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s0_valid),
    .item_o     (s0_item)
  );

  kir_xlate u_xlate (
    .item_i  (s0_item),
    .xlate_o (xlate)
  );

  kir_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (s0_item),
    .xlate_i     (xlate),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  assign out_o.valid        = out_valid;
  assign out_o.read_data    = result.read_data;
  assign out_o.event_unused = result.event_unused;
  assign out_o.irq_active   = result.irq_active;
  assign out_o.irq_level    = result.irq_level;

endmodule

>>> sv/kir_chk.sv
// kir_chk: port-level checks on the keyboard interface top level
// bound to keyboard_interface_registers; depends on kir_pkg for widths
`timescale 1ns / 1ps

module kir_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [kir_pkg::CodeW-1:0]  read_data_i,
  input logic                       event_unused_i,
  input logic [kir_pkg::LevelW-1:0] irq_level_i
);
  import kir_pkg::*;

  // an empty result register always leaves room for a request beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready while output empty");

  // a key event reported unused never carries read data
  a_unused_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && event_unused_i) |-> (read_data_i == '0))
    else $error("unused key event with read data");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(read_data_i) && $stable(event_unused_i) &&
       $stable(irq_level_i)))
    else $error("stalled result beat changed");

  // no result beat appears right after reset without a request
  a_no_beat_from_nothing: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result beat out of reset");

endmodule

bind keyboard_interface_registers kir_chk u_kir_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .read_data_i    (out_o.read_data),
  .event_unused_i (out_o.event_unused),
  .irq_level_i    (out_o.irq_level)
);

>>> dv/keyboard_interface_registers_tb.sv
// keyboard_interface_registers_tb: request/response checker for the keyboard interface block
// drives kir_in_if beats, predicts every response beat and compares it on kir_out_if
// depends on kir_pkg, kir_if and keyboard_interface_registers
`timescale 1ns / 1ps

module keyboard_interface_registers_tb;
  import kir_pkg::*;

  // request codes the package leaves unnamed; the block ignores them
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned BEATS_PER_PH = 570;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned REPORT_MAX   = 10;

  // key codes for dense key numbers 10..63
  localparam logic [KeyW-1:0] KEY_SYM [10:63] = '{
    'o53, 'o61, 'o62, 'o63, 'o64, 'o65, 'o66, 'o67, 'o70, 'o71,
    'o01, 'o02, 'o03, 'o04, 'o05, 'o06, 'o07, 'o10, 'o11, 'o12, 'o13, 'o14, 'o15,
    'o16, 'o17, 'o20, 'o21, 'o22, 'o23, 'o24, 'o25, 'o26, 'o27, 'o30, 'o31, 'o32,
    'o60, 'o55, 'o52, 'o50, 'o51, 'o73, 'o72, 'o34, 'o34, 'o54, 'o56, 'o57,
    'o77, 'o74, 'o74, 'o45, 'o33, 'o40
  };

  // console character to full code; 0100 shift, 0200 control, 0400 top
  localparam logic [CodeW-1:0] CHAR_CODE [128] = '{
    'o000, 'o201, 'o202, 'o203, 'o204, 'o205, 'o206, 'o207,
    'o210, 'o045, 'o035, 'o047, 'o046, 'o033, 'o216, 'o217,
    'o220, 'o221, 'o222, 'o223, 'o224, 'o225, 'o226, 'o227,
    'o230, 'o231, 'o232, 'o077, 'o234, 'o235, 'o000, 'o237,
    'o040, 'o154, 'o431, 'o422, 'o166, 'o167, 'o424, 'o411,
    'o050, 'o051, 'o052, 'o053, 'o054, 'o055, 'o056, 'o057,
    'o060, 'o061, 'o062, 'o063, 'o064, 'o065, 'o066, 'o067,
    'o070, 'o071, 'o072, 'o073, 'o404, 'o410, 'o406, 'o456,
    'o405, 'o101, 'o102, 'o103, 'o104, 'o105, 'o106, 'o107,
    'o110, 'o111, 'o112, 'o113, 'o114, 'o115, 'o116, 'o117,
    'o120, 'o121, 'o122, 'o123, 'o124, 'o125, 'o126, 'o127,
    'o130, 'o131, 'o132, 'o450, 'o034, 'o451, 'o000, 'o471,
    'o425, 'o001, 'o002, 'o003, 'o004, 'o005, 'o006, 'o007,
    'o010, 'o011, 'o012, 'o013, 'o014, 'o015, 'o016, 'o017,
    'o020, 'o021, 'o022, 'o023, 'o024, 'o025, 'o026, 'o027,
    'o030, 'o031, 'o032, 'o417, 'o153, 'o420, 'o170, 'o074
  };

  typedef struct packed {
    logic [2:0]        op;
    logic [6:0]        key;
    logic              down;
    logic [6:0]        ch;
    logic [LevelW-1:0] lvl;
    logic              given;
    logic [CodeW-1:0]  rd;
    logic              unused;
    logic              irq;
    logic [LevelW-1:0] lvl_o;
  } stim_row_t;

  localparam int unsigned STIM_ROWS = 27;

  // given = 1: the response is written out here; otherwise the predictor supplies it
  localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
    // straight after reset
    '{REQ_RD_STATUS, 7'd0,   1'b0, 7'd0,   3'd0, 1'b1, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_RD_CODE,   7'd0,   1'b0, 7'd0,   3'd0, 1'b1, 10'd0, 1'b0, 1'b0, 3'd0},
    // unmapped keys at both ends, the second with other fields at all ones
    '{REQ_KEY,       7'd0,   1'b1, 7'd0,   3'd0, 1'b1, 10'd0, 1'b1, 1'b0, 3'd0},
    '{REQ_KEY,       7'd127, 1'b1, 7'd127, 3'd7, 1'b1, 10'd0, 1'b1, 1'b0, 3'd0},
    // latch at level zero: done but no interrupt
    '{REQ_KEY,       7'd20,  1'b1, 7'd0,   3'd0, 1'b1, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_RD_STATUS, 7'd0,   1'b0, 7'd0,   3'd0, 1'b1, 10'd8, 1'b0, 1'b0, 3'd0},
    '{REQ_RD_CODE,   7'd0,   1'b0, 7'd0,   3'd0, 1'b1, 10'd1, 1'b0, 1'b0, 3'd0},
    '{REQ_WR_LEVEL,  7'd0,   1'b0, 7'd0,   3'd7, 1'b1, 10'd0, 1'b0, 1'b0, 3'd7},
    // character zero latches nothing
    '{REQ_ASCII,     7'd0,   1'b0, 7'd0,   3'd0, 1'b1, 10'd0, 1'b0, 1'b0, 3'd7},
    // all four modifiers down, caps lock standing in for control
    '{REQ_KEY,       7'd1,   1'b1, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd5,   1'b1, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd7,   1'b1, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd9,   1'b1, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd63,  1'b1, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    // release of an ordinary key
    '{REQ_KEY,       7'd63,  1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    // level rewrite keeps the pending interrupt
    '{REQ_WR_LEVEL,  7'd0,   1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_RD_CODE,   7'd0,   1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_ASCII,     7'd0,   1'b0, 7'd127, 3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_WR_DATA,   7'd127, 1'b1, 7'd127, 3'd7, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_RSVD6,     7'd127, 1'b1, 7'd127, 3'd7, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_RSVD7,     7'd127, 1'b1, 7'd127, 3'd7, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    // shift, control and meta up through other keys of their groups
    '{REQ_KEY,       7'd2,   1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd4,   1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd8,   1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_WR_LEVEL,  7'd0,   1'b0, 7'd0,   3'd3, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_KEY,       7'd10,  1'b1, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0},
    '{REQ_RD_STATUS, 7'd0,   1'b0, 7'd0,   3'd0, 1'b0, 10'd0, 1'b0, 1'b0, 3'd0}
  };

  logic clk_i;
  logic rst_ni;

  kir_in_if  req_if ();
  kir_out_if rsp_if ();

  keyboard_interface_registers uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // predicted interface state
  logic [LevelW-1:0] level_q;
  logic              done_q;
  logic [CodeW-1:0]  code_q;
  logic [ModW-1:0]   mods_q;
  logic              irq_q;

  result_t     pending_rsp_q[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  logic        want_hold;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void note_failure(input string what, input result_t want,
                                       input result_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $write("%0t mismatch (%s): exp rd=%0o unused=%0b irq=%0b lvl=%0d, ",
             $realtime, what, want.read_data, want.event_unused, want.irq_active,
             want.irq_level);
      $display("got rd=%0o unused=%0b irq=%0b lvl=%0d",
               got.read_data, got.event_unused, got.irq_active, got.irq_level);
    end
  endfunction

  function automatic void latch_code(input logic [CodeW-1:0] code);
    code_q = code;
    done_q = 1'b1;
    if (level_q != '0)
      irq_q = 1'b1;
  endfunction

  // applies one request to the predicted state and returns its response beat
  function automatic result_t predict_response(input item_t it);
    result_t rsp;
    int      mod_idx;
    rsp = '0;
    case (it.req_type)
      REQ_KEY: begin
        if (it.key_id >= 7'd1 && it.key_id <= 7'd9) begin
          // shift 1-2, control 3-5, top 6-7, meta 8-9
          mod_idx = (it.key_id <= 7'd2) ? 0 : (it.key_id <= 7'd5) ? 1 :
                    (it.key_id <= 7'd7) ? 2 : 3;
          mods_q[mod_idx] = it.key_down;
        end else if (it.key_down && it.key_id >= 7'd10 && it.key_id <= 7'd63) begin
          latch_code({mods_q, KEY_SYM[it.key_id]});
        end else begin
          rsp.event_unused = 1'b1;
        end
      end
      REQ_ASCII: begin
        if (it.ascii_char != '0)
          latch_code(CHAR_CODE[it.ascii_char]);
      end
      REQ_WR_LEVEL: level_q = it.level_value;
      REQ_RD_STATUS: rsp.read_data = {6'b0, done_q, level_q};
      REQ_RD_CODE: begin
        done_q = 1'b0;
        irq_q  = 1'b0;
        rsp.read_data = code_q;
      end
      default: ;
    endcase
    rsp.irq_active = irq_q;
    rsp.irq_level  = level_q;
    return rsp;
  endfunction

  // mapped key presses and modifier traffic among other requests, with some noise around them
  function automatic item_t random_request();
    item_t       it;
    int unsigned pick;
    int unsigned sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    it.key_id      = 7'($urandom_range(127));
    it.key_down    = 1'($urandom_range(1));
    it.ascii_char  = 7'($urandom_range(127));
    it.level_value = 3'($urandom_range(7));
    if (pick < 40) begin
      it.req_type = REQ_KEY;
      if (sub < 55) begin
        it.key_id   = 7'($urandom_range(63, 10));
        it.key_down = ($urandom_range(99) < 80);
      end else if (sub < 85) begin
        it.key_id = 7'($urandom_range(9, 1));
      end else begin
        it.key_id = (sub < 92) ? 7'd0 : 7'($urandom_range(127, 64));
      end
    end else if (pick < 60) begin
      it.req_type = REQ_ASCII;
    end else if (pick < 75) begin
      it.req_type = REQ_RD_CODE;
    end else if (pick < 85) begin
      it.req_type = REQ_RD_STATUS;
    end else if (pick < 93) begin
      it.req_type = REQ_WR_LEVEL;
    end else if (pick < 98) begin
      it.req_type = REQ_WR_DATA;
    end else begin
      it.req_type = $urandom_range(1) ? REQ_RSVD7 : REQ_RSVD6;
    end
    return it;
  endfunction

  // offers one request beat and queues its response once it is taken
  task automatic send_request(input item_t it, input logic given, input result_t fixed_rsp);
    result_t rsp;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= it.req_type;
    req_if.key_id      <= it.key_id;
    req_if.key_down    <= it.key_down;
    req_if.ascii_char  <= it.ascii_char;
    req_if.level_value <= it.level_value;
    do @(posedge clk_i); while (!req_if.ready);
    rsp = predict_response(it);
    pending_rsp_q.push_back(given ? fixed_rsp : rsp);
  endtask

  // response side: random stalls, plus one long hold-off so the block backs up
  initial begin : rsp_side
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (want_hold && !hold_done) begin
        rsp_if.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    result_t got;
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.read_data    = rsp_if.read_data;
      got.event_unused = rsp_if.event_unused;
      got.irq_active   = rsp_if.irq_active;
      got.irq_level    = rsp_if.irq_level;
      if (pending_rsp_q.size() == 0) begin
        note_failure("unexpected beat", '0, got);
      end else begin
        want = pending_rsp_q.pop_front();
        if (got.read_data !== want.read_data || got.event_unused !== want.event_unused ||
            got.irq_active !== want.irq_active || got.irq_level !== want.irq_level)
          note_failure("response", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    item_t     it;
    result_t   fixed_rsp;
    stim_row_t row;
    fail_count   = 0;
    cycle_count  = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    want_hold    = 1'b0;
    level_q = '0;
    done_q  = 1'b0;
    code_q  = '0;
    mods_q  = '0;
    irq_q   = 1'b0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= '0;
    req_if.key_id      <= '0;
    req_if.key_down    <= 1'b0;
    req_if.ascii_char  <= '0;
    req_if.level_value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < STIM_ROWS; i++) begin
      row = STIM_TABLE[i];
      it.req_type    = row.op;
      it.key_id      = row.key;
      it.key_down    = row.down;
      it.ascii_char  = row.ch;
      it.level_value = row.lvl;
      fixed_rsp.read_data    = row.rd;
      fixed_rsp.event_unused = row.unused;
      fixed_rsp.irq_active   = row.irq;
      fixed_rsp.irq_level    = row.lvl_o;
      send_request(it, row.given, fixed_rsp);
    end

    // three idling patterns: sender light, then receiver light, then flat out
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 63 : 0;
      snk_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 20 : 0;
      if (ph == 2)
        want_hold = 1'b1;
      for (int n = 0; n < BEATS_PER_PH; n++)
        send_request(random_request(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/kir_pkg.sv
sv/kir_if.sv
sv/kir_in_reg.sv
sv/kir_xlate.sv
sv/kir_exec.sv
sv/keyboard_interface_registers.sv
sv/kir_chk.sv
dv/keyboard_interface_registers_tb.sv
